### rtl/srpg_pkg.sv
package srpg_pkg;

  localparam int unsigned PERIOD_W = 13;
  localparam int unsigned DIV_W    = 5;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned SPD_W    = 8;
  localparam int unsigned PROD_W   = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);
  localparam logic [DIV_W-1:0] CNT_MAX = '1;

  // floor(x / 100) == (x * RECIP) >> RECIP_SH for every x below 2**PROD_W
  localparam int unsigned RECIP_SH = 27;
  localparam int unsigned RECIP_W  = 21;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(1342178);

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVER_ENABLE = CFG_IDX_W'(1);

  localparam logic [1:0] MODE_HALF    = 2'd1;
  localparam logic [1:0] MODE_QUARTER = 2'd2;

  typedef struct packed {
    logic [PERIOD_W-1:0] target;
    logic [DIV_W-1:0]    divider;
    logic                negative;
    logic                spd_nz;
  } cmd_t;

  typedef struct packed {
    logic                step;
    logic                dir;
    logic [PERIOD_W-1:0] period;
    logic                at_target;
  } res_t;

  function automatic logic [PERIOD_W-1:0] div100(input logic [PROD_W-1:0] x);
    logic [PROD_W+RECIP_W-1:0] p;
    p = (PROD_W+RECIP_W)'(x) * (PROD_W+RECIP_W)'(RECIP);
    return p[RECIP_SH +: PERIOD_W];
  endfunction

endpackage

### rtl/srpg_fifo.sv
module srpg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("fifo count beyond depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("fifo count missed a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (wr_ptr_q == rd_ptr_q))
    else $error("fifo pointers disagree with count");

endmodule

### rtl/srpg_front.sv
module srpg_front #(
  parameter int unsigned SLOW_PERIOD   = 5500,
  parameter int unsigned FAST_PERIOD   = 990,
  parameter int unsigned SLOW_RAMP_DIV = 20,
  parameter int unsigned FAST_RAMP_DIV = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [srpg_pkg::SPD_W-1:0] speed_i,
  input  logic [srpg_pkg::PCT_W-1:0]       accel_i,
  output logic                             cmd_valid_o,
  input  logic                             cmd_ready_i,
  output srpg_pkg::cmd_t                   cmd_o
);

  localparam logic [srpg_pkg::PROD_W-1:0] T_SPAN =
    srpg_pkg::PROD_W'(SLOW_PERIOD - FAST_PERIOD);
  localparam logic [srpg_pkg::PROD_W-1:0] D_SPAN =
    srpg_pkg::PROD_W'(SLOW_RAMP_DIV - FAST_RAMP_DIV);

  logic                          a_valid_q;
  logic [srpg_pkg::PROD_W-1:0]   prod_t_q, prod_t_d;
  logic [srpg_pkg::PROD_W-1:0]   prod_d_q, prod_d_d;
  logic                          neg_q, nz_q;
  logic [srpg_pkg::SPD_W-1:0]    mag;
  logic [srpg_pkg::PCT_W-1:0]    spd, acc;
  logic                          advance;

  always_comb begin
    mag = speed_i[srpg_pkg::SPD_W-1] ? srpg_pkg::SPD_W'(-speed_i)
                                     : srpg_pkg::SPD_W'(speed_i);
    spd = (mag > srpg_pkg::SPD_W'(srpg_pkg::PCT_MAX)) ? srpg_pkg::PCT_MAX
                                                      : mag[srpg_pkg::PCT_W-1:0];
    acc = (accel_i > srpg_pkg::PCT_MAX) ? srpg_pkg::PCT_MAX : accel_i;
    prod_t_d = T_SPAN * srpg_pkg::PROD_W'(spd);
    prod_d_d = D_SPAN * srpg_pkg::PROD_W'(acc);
  end

  assign advance    = !a_valid_q || cmd_ready_i;
  assign in_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      prod_t_q <= prod_t_d;
      prod_d_q <= prod_d_d;
      neg_q    <= speed_i[srpg_pkg::SPD_W-1];
      nz_q     <= (spd != '0);
    end
  end

  logic [srpg_pkg::PERIOD_W-1:0] qd;

  always_comb begin
    qd               = srpg_pkg::div100(prod_d_q);
    cmd_o.target     = srpg_pkg::PERIOD_W'(SLOW_PERIOD) - srpg_pkg::div100(prod_t_q);
    cmd_o.divider    = srpg_pkg::DIV_W'(SLOW_RAMP_DIV) - qd[srpg_pkg::DIV_W-1:0];
    cmd_o.negative   = neg_q;
    cmd_o.spd_nz     = nz_q;
  end

  assign cmd_valid_o = a_valid_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !cmd_ready_i) |=> (a_valid_q && $stable(prod_t_q)))
    else $error("front stage dropped a stalled item");

  a_target_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> (cmd_o.target >= srpg_pkg::PERIOD_W'(FAST_PERIOD)
                   && cmd_o.target <= srpg_pkg::PERIOD_W'(SLOW_PERIOD)))
    else $error("target period out of range");

  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && neg_q) |-> nz_q)
    else $error("negative speed classified as zero");

endmodule

### rtl/srpg_back.sv
module srpg_back #(
  parameter int unsigned SLOW_PERIOD   = 5500,
  parameter int unsigned FAST_PERIOD   = 990,
  parameter int unsigned SLOW_RAMP_DIV = 20,
  parameter int unsigned RAMP_STEP     = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  srpg_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output srpg_pkg::res_t res_o
);

  localparam logic [srpg_pkg::PERIOD_W-1:0] STEP_EXT =
    srpg_pkg::PERIOD_W'(RAMP_STEP);

  logic [srpg_pkg::PERIOD_W-1:0] cnt_q, cnt_d, cur_q, cur_d, tgt_q, tgt_d;
  logic [srpg_pkg::DIV_W-1:0]    tc_q, tc_d, tc_inc;
  logic                          step_q, step_d, dir_q, dir_d;
  logic [srpg_pkg::PERIOD_W-1:0] gap, move;
  logic                          fire, match;

  assign fire        = cmd_valid_i && res_ready_i;
  assign cmd_ready_o = res_ready_i;
  assign res_valid_o = cmd_valid_i;
  assign match       = (cnt_q >= cur_q);

  // the divider of the incoming item is always the one in force
  always_comb begin
    cnt_d  = cnt_q;
    cur_d  = cur_q;
    tgt_d  = cmd_i.target;
    tc_d   = tc_q;
    step_d = step_q;
    dir_d  = dir_q;
    if (cmd_i.target != tgt_q) begin
      if (cmd_i.negative) begin
        dir_d = 1'b1;
      end else if (cmd_i.spd_nz) begin
        dir_d = 1'b0;
      end
    end
    gap  = (cur_q > tgt_d) ? (cur_q - tgt_d) : (tgt_d - cur_q);
    move = (gap < STEP_EXT) ? gap : STEP_EXT;
    tc_inc = (tc_q == srpg_pkg::CNT_MAX) ? tc_q : tc_q + 1'b1;
    if (match) begin
      cnt_d  = '0;
      step_d = !step_q;
      tc_d   = tc_inc;
      if (tc_inc >= cmd_i.divider && cur_q != tgt_d) begin
        cur_d = (cur_q > tgt_d) ? (cur_q - move) : (cur_q + move);
        tc_d  = '0;
      end
    end else begin
      cnt_d = cnt_q + 1'b1;
    end
    res_o.step      = step_d;
    res_o.dir       = dir_d;
    res_o.period    = cur_d;
    res_o.at_target = (cur_d == tgt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cur_q  <= srpg_pkg::PERIOD_W'(SLOW_PERIOD);
      tgt_q  <= srpg_pkg::PERIOD_W'(SLOW_PERIOD);
      tc_q   <= '0;
      step_q <= 1'b0;
      dir_q  <= 1'b0;
    end else if (fire) begin
      cnt_q  <= cnt_d;
      cur_q  <= cur_d;
      tgt_q  <= tgt_d;
      tc_q   <= tc_d;
      step_q <= step_d;
      dir_q  <= dir_d;
    end
  end

  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_q >= srpg_pkg::PERIOD_W'(FAST_PERIOD)
     && cur_q <= srpg_pkg::PERIOD_W'(SLOW_PERIOD)))
    else $error("current period left its range");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && match) |=> (cnt_q == '0))
    else $error("counter did not restart on match");

  a_dir_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(dir_q) && $stable(cur_q))
    else $error("state moved without an item");

endmodule

### rtl/stepper_ramp_pulse_generator_unit.sv
// Step-clock generator with a linear speed ramp for a stepper driver.
// Input channel (push/full): one item per prescaled timer tick, carrying a
// signed speed percent and an acceleration percent; an item is taken on a
// clock edge with push high and full low.
// Result channel (empty/pop): exactly one result per item, in order: the
// step line, direction, microstep select pins, enable, current half-period
// and an at-target flag, all as they stand after that tick.
// Configuration channel (cfg_valid_i/cfg_ready_o): index 0 step mode,
// index 1 driver enable; ready is always high; write only while idle.
// Path: a pushed item is taken into the front product register, then the command
// queue, then the result queue written by the back end; a stall can hold it in
// any of these, and it can be popped once it stands on the result ports.
// Throughput: one item per cycle while the receiver keeps popping, set by the state update in
// the back end; the front and back are joined by a 2-entry queue.
// Reset: period and target at the slowest speed, counters and lines low,
// both queues empty, config cleared.
// Receiver stall: results collect in a 2-entry output queue, then the
// command queue and the front register fill and full rises; nothing is dropped.
module stepper_ramp_pulse_generator_unit #(
  parameter int unsigned SLOW_PERIOD   = 5500,
  parameter int unsigned FAST_PERIOD   = 990,
  parameter int unsigned SLOW_RAMP_DIV = 20,
  parameter int unsigned FAST_RAMP_DIV = 4,
  parameter int unsigned RAMP_STEP     = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [srpg_pkg::SPD_W-1:0]   speed_percent_i,
  input  logic [srpg_pkg::PCT_W-1:0]          accel_percent_i,
  output logic                                empty,
  input  logic                                pop,
  output logic                                step_level_o,
  output logic                                direction_level_o,
  output logic                                mode_bit_zero_o,
  output logic                                mode_bit_one_o,
  output logic                                enable_level_o,
  output logic [srpg_pkg::PERIOD_W-1:0]       period_now_o,
  output logic                                at_target_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [srpg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [srpg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned CMD_W = $bits(srpg_pkg::cmd_t);
  localparam int unsigned RES_W = $bits(srpg_pkg::res_t);

  logic [1:0] step_mode_q;
  logic       drv_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_mode_q <= '0;
      drv_en_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        srpg_pkg::CFG_STEP_MODE:     step_mode_q <= cfg_data_i[1:0];
        srpg_pkg::CFG_DRIVER_ENABLE: drv_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic           front_ready, f_valid, cq_full, cq_empty, cq_pop;
  srpg_pkg::cmd_t f_cmd, cq_cmd;
  logic [CMD_W-1:0] cq_out;

  assign full = !front_ready;

  srpg_front #(
    .SLOW_PERIOD  (SLOW_PERIOD),
    .FAST_PERIOD  (FAST_PERIOD),
    .SLOW_RAMP_DIV(SLOW_RAMP_DIV),
    .FAST_RAMP_DIV(FAST_RAMP_DIV)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .in_ready_o (front_ready),
    .speed_i    (speed_percent_i),
    .accel_i    (accel_percent_i),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(!cq_full),
    .cmd_o      (f_cmd)
  );

  srpg_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid),
    .data_i (f_cmd),
    .full_o (cq_full),
    .pop_i  (cq_pop),
    .data_o (cq_out),
    .empty_o(cq_empty)
  );

  assign cq_cmd = srpg_pkg::cmd_t'(cq_out);

  logic           rq_full, b_valid;
  srpg_pkg::res_t b_res, rq_res;
  logic [RES_W-1:0] rq_out;

  srpg_back #(
    .SLOW_PERIOD  (SLOW_PERIOD),
    .FAST_PERIOD  (FAST_PERIOD),
    .SLOW_RAMP_DIV(SLOW_RAMP_DIV),
    .RAMP_STEP    (RAMP_STEP)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cq_empty),
    .cmd_ready_o(cq_pop),
    .cmd_i      (cq_cmd),
    .res_valid_o(b_valid),
    .res_ready_i(!rq_full),
    .res_o      (b_res)
  );

  srpg_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (b_valid),
    .data_i (b_res),
    .full_o (rq_full),
    .pop_i  (pop),
    .data_o (rq_out),
    .empty_o(empty)
  );

  assign rq_res            = srpg_pkg::res_t'(rq_out);
  assign step_level_o      = rq_res.step;
  assign direction_level_o = rq_res.dir;
  assign period_now_o      = rq_res.period;
  assign at_target_o       = rq_res.at_target;
  assign mode_bit_zero_o   = (step_mode_q == srpg_pkg::MODE_HALF);
  assign mode_bit_one_o    = (step_mode_q == srpg_pkg::MODE_QUARTER);
  assign enable_level_o    = drv_en_q;

endmodule

### test/step_ramp_checker.sv
`timescale 1ns / 1ps

module step_ramp_checker #(
  parameter int unsigned SLOW_PERIOD   = 5500,
  parameter int unsigned FAST_PERIOD   = 990,
  parameter int unsigned SLOW_RAMP_DIV = 20,
  parameter int unsigned FAST_RAMP_DIV = 4,
  parameter int unsigned RAMP_STEP     = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic                              full_i,
  input  logic [srpg_pkg::SPD_W-1:0]        speed_percent_i,
  input  logic [srpg_pkg::PCT_W-1:0]        accel_percent_i,
  input  logic                              empty_i,
  input  logic                              pop_i,
  input  logic                              step_level_i,
  input  logic                              direction_level_i,
  input  logic                              mode_bit_zero_i,
  input  logic                              mode_bit_one_i,
  input  logic                              enable_level_i,
  input  logic [srpg_pkg::PERIOD_W-1:0]     period_now_i,
  input  logic                              at_target_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [srpg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [srpg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int                                fail_count_o
);
  import srpg_pkg::*;

  typedef struct packed {
    logic                step;
    logic                dir;
    logic                mode0;
    logic                mode1;
    logic                enable;
    logic [PERIOD_W-1:0] period;
    logic                at_target;
  } pin_state_t;

  pin_state_t          expected_pins[$];
  int                  pending;
  int                  mismatches;

  logic [1:0]          step_mode_q;
  logic                enable_q;
  logic [PERIOD_W-1:0] tick_q;
  logic [PERIOD_W-1:0] period_q;
  logic [PERIOD_W-1:0] target_q;
  logic [DIV_W-1:0]    divider_q;
  logic [DIV_W-1:0]    toggles_q;
  logic                step_q;
  logic                dir_q;

  assign fail_count_o = mismatches + pending;

  initial begin
    pending    = 0;
    mismatches = 0;
  end

  task automatic advance_tick(input logic [SPD_W-1:0] raw, input logic [PCT_W-1:0] acc_raw);
    int         mag;
    int         spd;
    int         acc;
    int         tgt;
    int         dv;
    int         gap;
    int         mv;
    pin_state_t e;
    mag = raw[SPD_W-1] ? 256 - int'(raw) : int'(raw);
    spd = (mag > 100) ? 100 : mag;
    acc = (int'(acc_raw) > 100) ? 100 : int'(acc_raw);
    tgt = SLOW_PERIOD - ((SLOW_PERIOD - FAST_PERIOD) * spd) / 100;
    dv  = SLOW_RAMP_DIV - ((SLOW_RAMP_DIV - FAST_RAMP_DIV) * acc) / 100;
    if (PERIOD_W'(tgt) != target_q) begin
      if (raw[SPD_W-1]) begin
        dir_q = 1'b1;
      end else if (spd != 0) begin
        dir_q = 1'b0;
      end
      target_q = PERIOD_W'(tgt);
    end
    divider_q = DIV_W'(dv);
    if (tick_q >= period_q) begin
      tick_q = '0;
      step_q = ~step_q;
      if (toggles_q != CNT_MAX) toggles_q = toggles_q + 1'b1;
      if (toggles_q >= divider_q && period_q != target_q) begin
        gap = (period_q > target_q) ? int'(period_q - target_q) : int'(target_q - period_q);
        mv  = (gap < int'(RAMP_STEP)) ? gap : int'(RAMP_STEP);
        if (period_q > target_q) begin
          period_q = period_q - PERIOD_W'(mv);
        end else begin
          period_q = period_q + PERIOD_W'(mv);
        end
        toggles_q = '0;
      end
    end else begin
      tick_q = tick_q + 1'b1;
    end
    e.step      = step_q;
    e.dir       = dir_q;
    e.mode0     = (step_mode_q == MODE_HALF);
    e.mode1     = (step_mode_q == MODE_QUARTER);
    e.enable    = enable_q;
    e.period    = period_q;
    e.at_target = (period_q == target_q);
    expected_pins.push_back(e);
    pending++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pin_state_t got;
    pin_state_t want;
    if (!rst_ni) begin
      step_mode_q = '0;
      enable_q    = 1'b0;
      tick_q      = '0;
      period_q    = PERIOD_W'(SLOW_PERIOD);
      target_q    = PERIOD_W'(SLOW_PERIOD);
      divider_q   = DIV_W'(SLOW_RAMP_DIV);
      toggles_q   = '0;
      step_q      = 1'b0;
      dir_q       = 1'b0;
      expected_pins.delete();
      pending     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_STEP_MODE) begin
          step_mode_q = cfg_data_i[1:0];
        end else if (cfg_index_i == CFG_DRIVER_ENABLE) begin
          enable_q = cfg_data_i[0];
        end
      end
      if (pop_i && !empty_i) begin
        got = '{step_level_i, direction_level_i, mode_bit_zero_i, mode_bit_one_i,
                enable_level_i, period_now_i, at_target_i};
        if (expected_pins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no item pending: period=%0d", $time, period_now_i);
        end else begin
          want = expected_pins.pop_front();
          pending--;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp step=%0b dir=%0b m0=%0b m1=%0b en=%0b per=%0d at=%0b",
                       $time, want.step, want.dir, want.mode0, want.mode1, want.enable,
                       want.period, want.at_target);
              $display("%0t:          got step=%0b dir=%0b m0=%0b m1=%0b en=%0b per=%0d at=%0b",
                       $time, got.step, got.dir, got.mode0, got.mode1, got.enable,
                       got.period, got.at_target);
            end
          end
        end
      end
      if (push_i && !full_i) advance_tick(speed_percent_i, accel_percent_i);
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import srpg_pkg::*;

  localparam logic [1:0] MODE_FULL   = 2'd0;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic signed [SPD_W-1:0] speed_percent;
  logic [PCT_W-1:0]      accel_percent;
  logic                  empty;
  logic                  pop;
  logic                  step_level;
  logic                  direction_level;
  logic                  mode_bit_zero;
  logic                  mode_bit_one;
  logic                  enable_level;
  logic [PERIOD_W-1:0]   period_now;
  logic                  at_target;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;

  int n_pushed;
  int n_popped;
  int snd_idle_pct;
  int rcv_idle_pct;
  bit hold_req;
  int held_spd;
  int held_acc;
  int run_left;

  int spd_edges[7] = '{0, 100, -100, 127, -128, 101, -101};
  int acc_edges[4] = '{0, 100, 127, 101};

  int dir_spd[16] = '{0, 100, -100, 0, 127, -128, 101, -101, 1, -1, 0, 50, -50, 100, 99, -99};
  int dir_acc[16] = '{0, 100, 0, 50, 127, 101, 100, 64, 1, 99, 0, 50, 25, 4, 17, 127};

  stepper_ramp_pulse_generator_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .speed_percent_i   (speed_percent),
    .accel_percent_i   (accel_percent),
    .empty             (empty),
    .pop               (pop),
    .step_level_o      (step_level),
    .direction_level_o (direction_level),
    .mode_bit_zero_o   (mode_bit_zero),
    .mode_bit_one_o    (mode_bit_one),
    .enable_level_o    (enable_level),
    .period_now_o      (period_now),
    .at_target_o       (at_target),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  step_ramp_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_i            (full),
    .speed_percent_i   (speed_percent),
    .accel_percent_i   (accel_percent),
    .empty_i           (empty),
    .pop_i             (pop),
    .step_level_i      (step_level),
    .direction_level_i (direction_level),
    .mode_bit_zero_i   (mode_bit_zero),
    .mode_bit_one_i    (mode_bit_one),
    .enable_level_i    (enable_level),
    .period_now_i      (period_now),
    .at_target_i       (at_target),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .fail_count_o      (fail_count)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic push_item(input int s, input int a);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    speed_percent <= s[SPD_W-1:0];
    accel_percent <= a[PCT_W-1:0];
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    n_pushed++;
  endtask

  task automatic drain();
    push <= 1'b0;
    wait (n_popped == n_pushed);
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic en);
    cfg_write(CFG_STEP_MODE, mode);
    cfg_write(CFG_DRIVER_ENABLE, {1'b0, en});
    cfg_valid <= 1'b0;
  endtask

  // speed held for a run of ticks, with some noise items mixed in
  task automatic push_random();
    int pick;
    if (run_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      held_spd = int'($urandom_range(0, 200)) - 100;
      else if (pick < 80) held_spd = $urandom_range(0, 255);
      else                held_spd = spd_edges[$urandom_range(0, 6)];
      pick = $urandom_range(0, 99);
      if (pick < 70)      held_acc = $urandom_range(0, 100);
      else if (pick < 90) held_acc = $urandom_range(0, 127);
      else                held_acc = acc_edges[$urandom_range(0, 3)];
      run_left = $urandom_range(1, 40);
    end
    run_left--;
    if ($urandom_range(0, 99) < 10) push_item($urandom_range(0, 255), $urandom_range(0, 127));
    else                            push_item(held_spd, held_acc);
  endtask

  initial begin
    pop = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rcv_idle_pct);
        @(posedge clk_i);
        if (pop && !empty) n_popped++;
      end
    end
  end

  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    speed_percent = '0;
    accel_percent = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    n_pushed      = 0;
    n_popped      = 0;
    hold_req      = 1'b0;
    run_left      = 0;
    snd_idle_pct  = 32;
    rcv_idle_pct  = 54;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(MODE_QUARTER, 1'b1);
    foreach (dir_spd[i]) push_item(dir_spd[i], dir_acc[i]);
    drain();

    set_config(MODE_HALF, 1'b0);
    repeat (600) push_random();
    drain();

    set_config(MODE_UNUSED, 1'b1);
    snd_idle_pct = 54;
    rcv_idle_pct = 32;
    for (int i = 0; i < 600; i++) begin
      if (i == 200) hold_req = 1'b1;
      if (i == 450) drain();
      push_random();
    end
    drain();

    set_config(MODE_FULL, 1'b0);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (100) push_random();
    drain();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) $display("All tests passed");
    else                 $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
rtl/srpg_pkg.sv
rtl/srpg_fifo.sv
rtl/srpg_front.sv
rtl/srpg_back.sv
rtl/stepper_ramp_pulse_generator_unit.sv
test/step_ramp_checker.sv
test/tb.sv
